[design/dwr_pkg.sv]
package dwr_pkg;
    localparam int MAX_WINDOW_DEF  = 1024;
    localparam int SAMPLE_BITS_DEF = 12;
    localparam int FIELD_BITS      = 12;
    localparam int FACTOR_BITS     = 7;
    localparam int GAIN_BITS       = 32;
    localparam int NUM_BITS        = 64;
    localparam int ROOT_BITS       = 40;
    localparam int CNT_BITS        = 20;
    localparam int VOLT_BITS       = 32;
    localparam logic [FACTOR_BITS-1:0] FACTOR_RESET = 7'd4;
    localparam logic [GAIN_BITS-1:0]   GAIN_RESET   = 32'd13520;
    localparam logic CFG_IDX_FACTOR = 1'b0;
    localparam logic CFG_IDX_GAIN   = 1'b1;

    typedef enum logic [2:0] {
        ST_ACC, ST_MUL_A, ST_MUL_B, ST_SQRT, ST_DIV, ST_GAIN, ST_OUT
    } t_state;
endpackage

[design/dwr_if.sv]
interface dwr_in_if;
    import dwr_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [FIELD_BITS-1:0] sample;
    logic                  last_sample;
    modport source (output valid, sample, last_sample, input ready);
    modport sink (input valid, sample, last_sample, output ready);
endinterface

interface dwr_out_if;
    import dwr_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [VOLT_BITS-1:0] rms_volts;
    logic [CNT_BITS-1:0]  rms_adc;
    logic                 used_raw_path;
    logic                 overflowed;
    modport source (output valid, rms_volts, rms_adc, used_raw_path, overflowed,
                    input ready);
    modport sink (input valid, rms_volts, rms_adc, used_raw_path, overflowed,
                  output ready);
endinterface

interface dwr_cfg_if;
    import dwr_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [31:0]          index;
    logic [GAIN_BITS-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

[design/decimated_window_rms.sv]
// the result is formed after the closing sample is taken, in the multiply states
// ST_MUL_A and ST_MUL_B, then a 40-step root, a 40-step divide and the gain state ST_GAIN
// throughput: one sample per cycle inside a window; after the closing sample the input
// stays blocked until the result is taken
// reset: synchronous active low, clears sums, registers to reset values, no result pending
module decimated_window_rms
    import dwr_pkg::*;
#(
    parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dwr_in_if.sink     i_in,
    dwr_out_if.source  o_out,
    dwr_cfg_if.sink    i_cfg
);
    localparam int WC_BITS  = $clog2(MAX_WINDOW + 1);
    localparam int BP_BITS  = SAMPLE_BITS + 6;
    localparam int RT_BITS  = SAMPLE_BITS + WC_BITS;
    localparam int RS_BITS  = 2 * SAMPLE_BITS + WC_BITS;
    localparam int BS_BITS  = 2 * BP_BITS + WC_BITS;
    localparam int X_BITS   = 2 * ROOT_BITS;
    localparam int REM_BITS = ROOT_BITS + 4;
    localparam logic [6:0] LAST_STEP = 7'(ROOT_BITS - 1);

    t_state r_state, n_state;
    logic [FACTOR_BITS-1:0] r_factor;
    logic [GAIN_BITS-1:0]   r_gain;
    logic [6:0]             r_wfac;
    logic [BP_BITS-1:0]     r_bpart;
    logic [6:0]             r_bpos;
    logic [WC_BITS-1:0]     r_wcnt;
    logic [RT_BITS-1:0]     r_rtot;
    logic [RS_BITS-1:0]     r_rsq;
    logic [RT_BITS-1:0]     r_btot;
    logic [BS_BITS-1:0]     r_bsq;
    logic [WC_BITS-1:0]     r_nblk;
    logic                   r_trunc;
    // shared arithmetic registers
    logic [NUM_BITS-1:0]    r_a;
    logic [X_BITS-1:0]      r_x;
    logic [REM_BITS-1:0]    r_rem;
    logic [ROOT_BITS-1:0]   r_root;
    logic [6:0]             r_step;
    logic [18:0]            r_den;
    logic                   r_raw;
    logic [CNT_BITS-1:0]    r_cnt;
    logic                   r_ovf;
    logic [VOLT_BITS-1:0]   r_volts;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = (r_state == ST_ACC);

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_factor <= FACTOR_RESET;
            r_gain   <= GAIN_RESET;
        end else if (i_cfg.valid) begin
            if (i_cfg.index == {31'd0, CFG_IDX_FACTOR}) r_factor <= i_cfg.data[FACTOR_BITS-1:0];
            else if (i_cfg.index == {31'd0, CFG_IDX_GAIN}) r_gain <= i_cfg.data;
        end
    end

    logic [SAMPLE_BITS-1:0]   s;
    logic [2*SAMPLE_BITS-1:0] sq_s;
    logic [6:0]               eff;
    logic [6:0]               wf;
    logic [BP_BITS-1:0]       bp_n;
    logic [2*BP_BITS-1:0]     bp_sq;
    logic                     take, blk_done;
    assign s     = SAMPLE_BITS'(i_in.sample);
    assign sq_s  = s * s;
    assign eff   = (r_factor == '0) ? 7'd1 : (r_factor > 7'd64) ? 7'd64 : r_factor;
    assign wf    = (r_wcnt == '0) ? eff : r_wfac;
    assign take  = i_in.valid && i_in.ready && (r_wcnt < WC_BITS'(MAX_WINDOW));
    assign bp_n  = r_bpart + BP_BITS'(s);
    assign bp_sq = bp_n * bp_n;
    assign blk_done = (r_bpos + 7'd1) >= wf;

    // difference of the two products, clamped at zero
    logic [NUM_BITS-1:0] diff;
    assign diff = (r_a > r_x[NUM_BITS-1:0]) ? r_a - r_x[NUM_BITS-1:0] : '0;

    // root trial of the shift-subtract unit
    logic [REM_BITS-1:0]  sq_rem, sq_trial;
    logic                 sq_ge;
    logic [ROOT_BITS-1:0] root_next;
    assign sq_rem    = {r_rem[REM_BITS-3:0], r_x[X_BITS-1:X_BITS-2]};
    assign sq_trial  = {2'b00, r_root, 2'b01};
    assign sq_ge     = sq_rem >= sq_trial;
    assign root_next = {r_root[ROOT_BITS-2:0], sq_ge};
    // divide trial
    logic [REM_BITS-1:0]  dv_rem;
    logic                 dv_ge;
    logic [ROOT_BITS-1:0] q_next;
    logic                 q_big;
    assign dv_rem = {r_rem[REM_BITS-2:0], r_x[X_BITS-1]};
    assign dv_ge  = (r_den != '0) && (dv_rem >= REM_BITS'(r_den));
    assign q_next = {r_root[ROOT_BITS-2:0], dv_ge};
    assign q_big  = q_next[ROOT_BITS-1:CNT_BITS] != '0;

    logic [63:0] prod_g;
    assign prod_g = 64'(r_cnt) * 64'(r_gain);

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_ACC:   if (i_in.valid && i_in.last_sample) n_state = ST_MUL_A;
            ST_MUL_A: n_state = ST_MUL_B;
            ST_MUL_B: n_state = ST_SQRT;
            ST_SQRT:  if (r_step == LAST_STEP) n_state = ST_DIV;
            ST_DIV:   if (r_step == LAST_STEP) n_state = ST_GAIN;
            ST_GAIN:  n_state = ST_OUT;
            ST_OUT:   if (o_out.ready) n_state = ST_ACC;
            default:  n_state = ST_ACC;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_ACC;
        else          r_state <= n_state;
    end

    // accumulation and arithmetic datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wfac <= 7'd1; r_bpart <= '0; r_bpos <= '0; r_wcnt <= '0;
            r_rtot <= '0; r_rsq <= '0; r_btot <= '0; r_bsq <= '0;
            r_nblk <= '0; r_trunc <= 1'b0; r_step <= '0;
        end else begin
            unique case (r_state)
                ST_ACC: if (i_in.valid) begin
                    if (take) begin
                        r_wfac <= wf;
                        r_wcnt <= r_wcnt + 1'b1;
                        r_rtot <= r_rtot + RT_BITS'(s);
                        r_rsq  <= r_rsq + RS_BITS'(sq_s);
                        if (blk_done) begin
                            r_btot <= r_btot + RT_BITS'(bp_n);
                            r_bsq  <= r_bsq + BS_BITS'(bp_sq);
                            r_nblk <= r_nblk + 1'b1;
                            r_bpart <= '0;
                            r_bpos  <= '0;
                        end else begin
                            r_bpart <= bp_n;
                            r_bpos  <= r_bpos + 7'd1;
                        end
                    end else begin
                        r_trunc <= 1'b1;
                    end
                end
                ST_MUL_A: begin
                    // a term: count times square sum
                    r_raw <= r_nblk < WC_BITS'(2);
                    if (r_nblk < WC_BITS'(2)) begin
                        r_a   <= 64'(r_wcnt) * 64'(r_rsq);
                        r_den <= 19'(r_wcnt);
                        r_x   <= X_BITS'(64'(r_rtot) * 64'(r_rtot));
                    end else begin
                        r_a   <= 64'(r_nblk) * 64'(r_bsq);
                        r_den <= 19'(r_nblk) * 19'(r_wfac);
                        r_x   <= X_BITS'(64'(r_btot) * 64'(r_btot));
                    end
                end
                ST_MUL_B: begin
                    // radicand is the difference scaled by 2^16
                    r_x    <= {diff, 16'd0};
                    r_rem  <= '0;
                    r_root <= '0;
                    r_step <= '0;
                end
                ST_SQRT: begin
                    r_step <= (r_step == LAST_STEP) ? 7'd0 : r_step + 7'd1;
                    r_root <= root_next;
                    if (r_step == LAST_STEP) begin
                        // root becomes the dividend
                        r_x   <= {root_next, {ROOT_BITS{1'b0}}};
                        r_rem <= '0;
                    end else begin
                        r_x   <= r_x << 2;
                        r_rem <= sq_ge ? sq_rem - sq_trial : sq_rem;
                    end
                end
                ST_DIV: begin
                    // quotient bits shift into root register
                    r_step <= (r_step == LAST_STEP) ? 7'd0 : r_step + 7'd1;
                    r_x    <= r_x << 1;
                    r_rem  <= dv_ge ? dv_rem - REM_BITS'(r_den) : dv_rem;
                    r_root <= q_next;
                    if (r_step == LAST_STEP) begin
                        r_cnt <= q_big ? '1 : q_next[CNT_BITS-1:0];
                        r_ovf <= r_trunc || q_big;
                    end
                end
                ST_GAIN: begin
                    // volts scaling with saturation
                    r_volts <= (prod_g[63:48] != '0) ? '1 : prod_g[47:16];
                    r_ovf   <= r_ovf || (prod_g[63:48] != '0);
                end
                ST_OUT: if (o_out.ready) begin
                    r_wfac <= 7'd1; r_bpart <= '0; r_bpos <= '0; r_wcnt <= '0;
                    r_rtot <= '0; r_rsq <= '0; r_btot <= '0; r_bsq <= '0;
                    r_nblk <= '0; r_trunc <= 1'b0; r_step <= '0;
                end
                default: ;
            endcase
        end
    end

    assign o_out.valid         = (r_state == ST_OUT);
    assign o_out.rms_volts     = r_volts;
    assign o_out.rms_adc       = r_cnt;
    assign o_out.used_raw_path = r_raw;
    assign o_out.overflowed    = r_ovf;

`ifndef SYNTHESIS
    a_ready_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready |-> !o_out.valid) else $error("ready while result pending");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.ready |=> o_out.valid) else $error("result dropped");
    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wcnt <= WC_BITS'(MAX_WINDOW)) else $error("window count overrun");
`endif
endmodule
